FILE: sv/spi_nor_flash_model_unit_assert.svh
// Assertion macros for the serial NOR flash model.
// No dependencies; taken in by the checker.
`ifndef SPI_NOR_FLASH_MODEL_UNIT_ASSERT_SVH
`define SPI_NOR_FLASH_MODEL_UNIT_ASSERT_SVH

// checked only out of reset
`define SNF_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define SNF_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: sv/snf_pkg.sv
// Shared types and constants for the serial NOR flash model.
// No dependencies.
package snf_pkg;

  localparam int FLASH_BYTES_DEF  = 65536;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int BLOCK_BYTES_DEF  = 65536;
  localparam int ADDR_W           = 24;
  localparam int Q_DEPTH          = 2;

  localparam logic [2:0] CNT_CHIP   = 3'd5;
  localparam logic [2:0] CNT_SECTOR = 3'd3;
  localparam logic [2:0] CNT_BLOCK  = 3'd4;
  localparam logic [2:0] CNT_PAGE   = 3'd2;
  localparam logic [7:0] ERASED     = 8'hFF;

  typedef enum logic [3:0] {
    CMD_WREN      = 4'd0,
    CMD_WRDI      = 4'd1,
    CMD_CHIP_ERS  = 4'd2,
    CMD_SECT_ERS  = 4'd3,
    CMD_BLOCK_ERS = 4'd4,
    CMD_STATUS    = 4'd5,
    CMD_READ      = 4'd6,
    CMD_PROG      = 4'd7,
    CMD_CLEARPROT = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    OP_WREN,
    OP_WRDI,
    OP_ERASE,
    OP_STATUS,
    OP_READ,
    OP_PROG
  } op_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SWEEP,
    BK_READ,
    BK_PROG
  } bk_state_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       is_status;
  } out_res_t;

  typedef struct packed {
    op_t               op;
    logic              fit;
    logic              addr_ok;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] last_addr;
    logic [2:0]        count;
    logic [7:0]        data;
    logic              last;
  } q_entry_t;

endpackage

FILE: sv/spi_nor_flash_model_unit.sv
// Top level of the serial NOR flash model: front end, request queue, back end.
// Depends on snf_pkg, snf_front, snf_queue, snf_back.
//
//   port group   dir  handshake                payload
//   in_*         in   start high, busy low      in_req (snf_pkg::in_req_t)
//   out_*        out  out_valid, one cycle      out_result (snf_pkg::out_res_t)
//
// Back end: a byte read or program that reaches the store moves on to BK_READ or
// BK_PROG (the store is read, then written for a program); an erase that runs
// sweeps SECTOR_BYTES, BLOCK_BYTES or FLASH_BYTES bytes, one byte per cycle.
// After reset a clearing pass over the whole store holds busy high.
// A two-entry queue lets the front end take requests while the back end works;
// busy rises when the queue is full. Results cannot be stalled.
module spi_nor_flash_model_unit #(
  parameter int FLASH_BYTES  = snf_pkg::FLASH_BYTES_DEF,
  parameter int SECTOR_BYTES = snf_pkg::SECTOR_BYTES_DEF,
  parameter int BLOCK_BYTES  = snf_pkg::BLOCK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  snf_pkg::in_req_t  in_req,
  output logic              out_valid,
  output snf_pkg::out_res_t out_result
);

  logic              push;
  snf_pkg::q_entry_t push_entry;
  logic              q_full;
  logic              q_valid;
  snf_pkg::q_entry_t q_head;
  logic              pop;
  logic              clearing;

  assign busy = q_full || clearing;

  snf_front #(
    .FLASH_BYTES (FLASH_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .accept(start && !busy),
    .in_req(in_req),
    .push  (push),
    .entry (push_entry)
  );

  snf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  snf_back #(
    .FLASH_BYTES(FLASH_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (q_head),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_result(out_result)
  );

endmodule

FILE: sv/snf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module snf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/snf_front.sv
// Front end: decodes a request and precomputes erase regions and range checks.
// Depends on snf_pkg.
module snf_front #(
  parameter int FLASH_BYTES  = snf_pkg::FLASH_BYTES_DEF,
  parameter int SECTOR_BYTES = snf_pkg::SECTOR_BYTES_DEF,
  parameter int BLOCK_BYTES  = snf_pkg::BLOCK_BYTES_DEF
) (
  input  logic              accept,
  input  snf_pkg::in_req_t  in_req,
  output logic              push,
  output snf_pkg::q_entry_t entry
);

  localparam logic [25:0] FlashSz = 26'(FLASH_BYTES);
  localparam logic [25:0] SectSz  = 26'(SECTOR_BYTES);
  localparam logic [25:0] BlkSz   = 26'(BLOCK_BYTES);

  logic [25:0] addr_w;
  logic [25:0] sect_base;
  logic [25:0] sect_top;
  logic [25:0] blk_base;
  logic [25:0] blk_top;

  always_comb begin
    addr_w    = {2'b00, in_req.address};
    sect_base = addr_w & ~(SectSz - 26'd1);
    sect_top  = sect_base + SectSz;
    blk_base  = addr_w & ~(BlkSz - 26'd1);
    blk_top   = blk_base + BlkSz;

    push            = accept;
    entry.op        = snf_pkg::OP_WREN;
    entry.fit       = 1'b0;
    entry.addr_ok   = addr_w < FlashSz;
    entry.addr      = in_req.address;
    entry.last_addr = in_req.address;
    entry.count     = snf_pkg::CNT_CHIP;
    entry.data      = in_req.data_byte;
    entry.last      = in_req.last_byte;

    case (snf_pkg::cmd_t'(in_req.command))
      snf_pkg::CMD_WREN: entry.op = snf_pkg::OP_WREN;
      snf_pkg::CMD_WRDI: entry.op = snf_pkg::OP_WRDI;
      snf_pkg::CMD_CHIP_ERS: begin
        entry.op        = snf_pkg::OP_ERASE;
        entry.fit       = 1'b1;
        entry.addr      = '0;
        entry.last_addr = 24'(FlashSz - 26'd1);
        entry.count     = snf_pkg::CNT_CHIP;
      end
      snf_pkg::CMD_SECT_ERS: begin
        entry.op        = snf_pkg::OP_ERASE;
        entry.fit       = sect_top <= FlashSz;
        entry.addr      = sect_base[23:0];
        entry.last_addr = 24'(sect_top - 26'd1);
        entry.count     = snf_pkg::CNT_SECTOR;
      end
      snf_pkg::CMD_BLOCK_ERS: begin
        entry.op        = snf_pkg::OP_ERASE;
        entry.fit       = blk_top <= FlashSz;
        entry.addr      = blk_base[23:0];
        entry.last_addr = 24'(blk_top - 26'd1);
        entry.count     = snf_pkg::CNT_BLOCK;
      end
      snf_pkg::CMD_STATUS: entry.op = snf_pkg::OP_STATUS;
      snf_pkg::CMD_READ:   entry.op = snf_pkg::OP_READ;
      snf_pkg::CMD_PROG:   entry.op = snf_pkg::OP_PROG;
      // clear protection has no effect on a two-bit status
      default: push = 1'b0;
    endcase
  end

endmodule

FILE: sv/snf_queue.sv
// Small request queue between the front end and the back end.
// Depends on snf_pkg.
module snf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  snf_pkg::q_entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              valid,
  output snf_pkg::q_entry_t head
);

  localparam int PW = $clog2(snf_pkg::Q_DEPTH);
  localparam int CW = $clog2(snf_pkg::Q_DEPTH + 1);

  snf_pkg::q_entry_t slot_r [snf_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = cnt_r == CW'(snf_pkg::Q_DEPTH);
  assign valid   = cnt_r != '0;
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(snf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(snf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

FILE: sv/snf_back.sv
// Back end: status latch, busy countdown, flash store and erase sweeps.
// Depends on snf_pkg and snf_ram.
module snf_back #(
  parameter int FLASH_BYTES = snf_pkg::FLASH_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  snf_pkg::q_entry_t head,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  output snf_pkg::out_res_t out_result
);

  localparam int AW = $clog2(FLASH_BYTES);

  snf_pkg::bk_state_t state_r, state_nxt;
  logic              latch_r, latch_nxt;
  logic              busyb_r, busyb_nxt;
  logic [2:0]        count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     end_r, end_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              oval_r, oval_nxt;
  snf_pkg::out_res_t ores_r, ores_nxt;
  logic [2:0]        count_dec;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  snf_ram #(
    .WIDTH(8),
    .DEPTH(FLASH_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= snf_pkg::BK_CLEAR;
      latch_r <= 1'b0;
      busyb_r <= 1'b0;
      count_r <= '0;
      ptr_r   <= '0;
      end_r   <= AW'(FLASH_BYTES - 1);
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      latch_r <= latch_nxt;
      busyb_r <= busyb_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      end_r   <= end_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    ores_r <= ores_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    latch_nxt = latch_r;
    busyb_nxt = busyb_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    end_nxt   = end_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    oval_nxt  = 1'b0;
    ores_nxt  = ores_r;
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = snf_pkg::ERASED;
    ram_raddr = head.addr[AW-1:0];
    count_dec = count_r - 3'd1;

    case (state_r)
      snf_pkg::BK_CLEAR, snf_pkg::BK_SWEEP: begin
        ram_we = 1'b1;
        if (ptr_r == end_r) begin
          state_nxt = snf_pkg::BK_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      snf_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (head.op)
            snf_pkg::OP_WREN: latch_nxt = 1'b1;
            snf_pkg::OP_WRDI: latch_nxt = 1'b0;
            snf_pkg::OP_ERASE: begin
              if (latch_r) begin
                latch_nxt = 1'b0;
                busyb_nxt = 1'b1;
                count_nxt = head.count;
                if (head.fit) begin
                  ptr_nxt   = head.addr[AW-1:0];
                  end_nxt   = head.last_addr[AW-1:0];
                  state_nxt = snf_pkg::BK_SWEEP;
                end
              end
            end
            snf_pkg::OP_STATUS: begin
              oval_nxt = 1'b1;
              ores_nxt.is_status  = 1'b1;
              ores_nxt.read_value = {6'd0, latch_r, busyb_r};
              if (count_r != '0) begin
                count_nxt = count_dec;
                if (count_dec == '0) begin
                  busyb_nxt = 1'b0;
                  ores_nxt.read_value = {6'd0, latch_r, 1'b0};
                end
              end
            end
            snf_pkg::OP_READ: begin
              if (head.addr_ok) begin
                state_nxt = snf_pkg::BK_READ;
              end else begin
                oval_nxt = 1'b1;
                ores_nxt.is_status  = 1'b0;
                ores_nxt.read_value = snf_pkg::ERASED;
              end
            end
            snf_pkg::OP_PROG: begin
              if (latch_r) begin
                if (head.last) begin
                  latch_nxt = 1'b0;
                  busyb_nxt = 1'b1;
                  count_nxt = snf_pkg::CNT_PAGE;
                end
                if (head.addr_ok) begin
                  addr_nxt  = head.addr[AW-1:0];
                  data_nxt  = head.data;
                  state_nxt = snf_pkg::BK_PROG;
                end
              end
            end
            default: ;
          endcase
        end
      end
      snf_pkg::BK_READ: begin
        oval_nxt = 1'b1;
        ores_nxt.is_status  = 1'b0;
        ores_nxt.read_value = ram_rdata;
        state_nxt = snf_pkg::BK_IDLE;
      end
      snf_pkg::BK_PROG: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = ram_rdata & data_r;
        state_nxt = snf_pkg::BK_IDLE;
      end
      default: state_nxt = snf_pkg::BK_IDLE;
    endcase
  end

  assign clearing   = state_r == snf_pkg::BK_CLEAR;
  assign out_valid  = oval_r;
  assign out_result = ores_r;

endmodule

FILE: sv/snf_checker.sv
// Port-level checker for the serial NOR flash model, bound to the top level.
// Depends on snf_pkg and spi_nor_flash_model_unit_assert.svh.
`include "spi_nor_flash_model_unit_assert.svh"

module snf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input snf_pkg::out_res_t out_result
);

  `SNF_ASSERT(a_status_upper_zero, clk, rst_n, (out_valid && out_result.is_status) |-> (out_result.read_value[7:2] == 6'd0), "status byte has upper bits set")
  `SNF_ASSERT_ALWAYS(a_busy_after_reset, clk, (!rst_n) |=> busy, "not busy during store clear")
  `SNF_ASSERT_ALWAYS(a_no_result_after_reset, clk, (!rst_n) |=> !out_valid, "result right after reset")

endmodule

bind spi_nor_flash_model_unit snf_checker u_snf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_result(out_result)
);

FILE: verif/snf_flash_checker.sv
`timescale 1ns / 100ps
// Checker for the serial NOR flash model: tracks accepted requests, predicts
// status and byte reads, and compares each result. Depends on snf_pkg.
module snf_flash_checker
  import snf_pkg::*;
#(
  parameter int FLASH_BYTES  = FLASH_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  out_res_t out_result,
  output int       mismatch_count,
  output int       reads_in_flight
);

  localparam int IW = $clog2(FLASH_BYTES);

  logic [7:0] flash_image [FLASH_BYTES];
  logic       wel;
  logic       wip;
  logic [2:0] wip_count;
  out_res_t   pending_reads [$];
  out_res_t   wanted;

  task automatic erase_span(input logic [23:0] addr, input int span, input logic [2:0] cnt);
    int unsigned base;
    if (!wel) return;
    base = int'(addr) & ~(span - 1);
    if (base + span <= FLASH_BYTES) begin
      for (int i = 0; i < span; i++) flash_image[IW'(base + i)] = ERASED;
    end
    wip       = 1'b1;
    wel       = 1'b0;
    wip_count = cnt;
  endtask

  task automatic apply_request(input in_req_t r);
    out_res_t res;
    case (r.command)
      CMD_WREN: wel = 1'b1;
      CMD_WRDI: wel = 1'b0;
      CMD_CHIP_ERS: erase_span('0, FLASH_BYTES, CNT_CHIP);
      CMD_SECT_ERS: erase_span(r.address, SECTOR_BYTES, CNT_SECTOR);
      CMD_BLOCK_ERS: erase_span(r.address, BLOCK_BYTES, CNT_BLOCK);
      CMD_STATUS: begin
        if (wip_count != 3'd0) begin
          wip_count = wip_count - 3'd1;
          if (wip_count == 3'd0) wip = 1'b0;
        end
        res.read_value = {6'b000000, wel, wip};
        res.is_status  = 1'b1;
        pending_reads.push_back(res);
      end
      CMD_READ: begin
        res.read_value = (r.address < FLASH_BYTES) ? flash_image[IW'(r.address)] : ERASED;
        res.is_status  = 1'b0;
        pending_reads.push_back(res);
      end
      CMD_PROG: begin
        if (wel) begin
          if (r.address < FLASH_BYTES) begin
            flash_image[IW'(r.address)] = flash_image[IW'(r.address)] & r.data_byte;
          end
          if (r.last_byte) begin
            wip       = 1'b1;
            wel       = 1'b0;
            wip_count = CNT_PAGE;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FLASH_BYTES; i++) flash_image[IW'(i)] = ERASED;
      wel       = 1'b0;
      wip       = 1'b0;
      wip_count = 3'd0;
      pending_reads.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid) begin
        if (pending_reads.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value %02h is_status %0b",
                   $time, out_result.read_value, out_result.is_status);
          mismatch_count++;
        end else begin
          wanted = pending_reads.pop_front();
          if (out_result.read_value !== wanted.read_value) begin
            $display("%0t: read_value mismatch: expected %02h, got %02h",
                     $time, wanted.read_value, out_result.read_value);
            mismatch_count++;
          end
          if (out_result.is_status !== wanted.is_status) begin
            $display("%0t: is_status mismatch: expected %0b, got %0b",
                     $time, wanted.is_status, out_result.is_status);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) apply_request(in_req);
    end
    reads_in_flight = pending_reads.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the serial NOR flash model bench: clock, reset and request stimulus.
// Depends on snf_pkg, spi_nor_flash_model_unit and snf_flash_checker.
module testbench;
  import snf_pkg::*;

  localparam int FLASH         = FLASH_BYTES_DEF;
  localparam int ITEM_TARGET   = 1850;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int TAIL_CYCLES   = 2 * FLASH + 64;
  localparam logic [3:0] CMD_UNUSED_LO = 4'(CMD_CLEARPROT + 1);
  localparam logic [3:0] CMD_UNUSED_HI = 4'hF;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  out_res_t out_result;
  int       mismatch_count;
  int       reads_in_flight;
  int       cycles = 0;
  int       items_sent = 0;
  int       big_erases_left = 3;
  int       sector_erases_left = 25;
  int       gap_pct [4] = '{0, 63, 0, 25};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  spi_nor_flash_model_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  snf_flash_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_result     (out_result),
    .mismatch_count (mismatch_count),
    .reads_in_flight(reads_in_flight)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic pace();
    if ($urandom_range(99) < gap_pct[(items_sent * 4 / ITEM_TARGET) % 4]) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [3:0] c, input logic [23:0] a, input logic [7:0] d,
                       input logic l);
    in_req_t r;
    r.command   = c;
    r.address   = a;
    r.data_byte = d;
    r.last_byte = l;
    pace();
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // hold requests until every outstanding read has returned
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (reads_in_flight != 0);
  endtask

  task automatic program_run();
    logic [23:0] base;
    int          n;
    logic        ends;
    case ($urandom_range(9))
      0: base = 24'($urandom);
      1: base = 24'(FLASH - $urandom_range(8, 1));
      default: base = 24'($urandom_range(1023));
    endcase
    n    = $urandom_range(8, 1);
    ends = ($urandom_range(9) != 0);
    if ($urandom_range(9) != 0) issue(CMD_WREN, 24'($urandom), 8'($urandom), 1'($urandom));
    for (int i = 0; i < n; i++) begin
      issue(CMD_PROG, base + 24'(i), 8'($urandom), (i == n - 1) && ends);
    end
    repeat ($urandom_range(6, 1)) issue(CMD_STATUS, 24'($urandom), 8'($urandom), 1'($urandom));
    repeat ($urandom_range(n + 2, 1)) begin
      issue(CMD_READ, base + 24'($urandom_range(n)), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic erase_run();
    logic [23:0] a;
    if (sector_erases_left == 0 && big_erases_left == 0) begin
      program_run();
      return;
    end
    if ($urandom_range(9) != 0) issue(CMD_WREN, 24'($urandom), 8'($urandom), 1'($urandom));
    if (sector_erases_left > 0 && (big_erases_left == 0 || $urandom_range(9) != 0)) begin
      sector_erases_left--;
      a = ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(FLASH - 1));
      issue(CMD_SECT_ERS, a, 8'($urandom), 1'($urandom));
    end else begin
      big_erases_left--;
      a = ($urandom_range(1) == 0) ? 24'($urandom_range(FLASH - 1)) : 24'($urandom);
      if ($urandom_range(1) == 0) issue(CMD_CHIP_ERS, a, 8'($urandom), 1'($urandom));
      else issue(CMD_BLOCK_ERS, a, 8'($urandom), 1'($urandom));
    end
    repeat ($urandom_range(6, 1)) issue(CMD_STATUS, 24'($urandom), 8'($urandom), 1'($urandom));
    repeat ($urandom_range(3, 1)) begin
      issue(CMD_READ, 24'($urandom_range(2047)), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic noise_item();
    logic [3:0] c;
    c = 4'($urandom_range(15));
    if (c == CMD_SECT_ERS) begin
      if (sector_erases_left > 0) sector_erases_left--;
      else c = CMD_READ;
    end else if (c == CMD_CHIP_ERS || c == CMD_BLOCK_ERS) begin
      if (big_erases_left > 0) big_erases_left--;
      else c = CMD_READ;
    end
    issue(c, 24'($urandom), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    issue(CMD_STATUS, 24'h000000, 8'h00, 1'b0);
    issue(CMD_READ, 24'h000000, 8'h00, 1'b0);
    issue(CMD_READ, 24'hFFFFFF, 8'hFF, 1'b1);
    // program and erase without the latch are dropped
    issue(CMD_PROG, 24'h000000, 8'h00, 1'b1);
    issue(CMD_CHIP_ERS, 24'h000000, 8'h00, 1'b0);
    issue(CMD_READ, 24'h000000, 8'h00, 1'b0);
    issue(CMD_WREN, 24'h000000, 8'h00, 1'b0);
    issue(CMD_WRDI, 24'h000000, 8'h00, 1'b0);
    issue(CMD_STATUS, 24'h000000, 8'h00, 1'b0);
    issue(CMD_WREN, 24'h000000, 8'h00, 1'b0);
    issue(CMD_PROG, 24'h000000, 8'h00, 1'b0);
    issue(CMD_PROG, 24'(FLASH - 1), 8'hA5, 1'b0);
    // last byte beyond the store still ends the run
    issue(CMD_PROG, 24'hFFFFFF, 8'h00, 1'b1);
    issue(CMD_STATUS, 24'h000000, 8'h00, 1'b0);
    // program while busy goes through on the latch alone
    issue(CMD_WREN, 24'h000000, 8'h00, 1'b0);
    issue(CMD_PROG, 24'h000001, 8'h3C, 1'b0);
    issue(CMD_CLEARPROT, 24'hFFFFFF, 8'hFF, 1'b1);
    issue(CMD_STATUS, 24'h000000, 8'h00, 1'b0);
    issue(CMD_READ, 24'h000001, 8'h00, 1'b0);
    issue(CMD_READ, 24'(FLASH - 1), 8'h00, 1'b0);
    issue(CMD_SECT_ERS, 24'h000123, 8'h00, 1'b0);
    issue(CMD_READ, 24'h000001, 8'h00, 1'b0);
    // erase regions that do not fit
    issue(CMD_WREN, 24'h000000, 8'h00, 1'b0);
    issue(CMD_BLOCK_ERS, 24'h010000, 8'h00, 1'b0);
    issue(CMD_WREN, 24'h000000, 8'h00, 1'b0);
    issue(CMD_SECT_ERS, 24'hFFFFFF, 8'h00, 1'b0);
    issue(CMD_READ, 24'(FLASH - 1), 8'h00, 1'b0);
    issue(CMD_WREN, 24'h000000, 8'h00, 1'b0);
    issue(CMD_CHIP_ERS, 24'h000000, 8'h00, 1'b0);
    issue(CMD_UNUSED_HI, 24'hFFFFFF, 8'hFF, 1'b1);
    issue(CMD_UNUSED_LO, 24'h000000, 8'h00, 1'b0);
    issue(CMD_STATUS, 24'h000000, 8'h00, 1'b0);
    issue(CMD_READ, 24'(FLASH - 1), 8'h00, 1'b0);
    drain();

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(99)) inside
        [0:59]:  program_run();
        [60:74]: erase_run();
        default: noise_item();
      endcase
      if ($urandom_range(19) == 0) drain();
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
